// ===== sv/hex_escape_unescaper_assert.svh =====
// Assertion macros for the hex escape decoder checks.
`ifndef HEX_ESCAPE_UNESCAPER_ASSERT_SVH
`define HEX_ESCAPE_UNESCAPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HEXU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HEXU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hexu_pkg.sv =====
// Shared types, constants and character helpers for the hex escape decoder.
package hexu_pkg;

    localparam logic [7:0] Backslash = 8'h5C;
    localparam logic [7:0] LetterX   = 8'h78;
    localparam int         MaxResults = 4;
    localparam int         CountW     = $clog2(MaxResults + 1);
    localparam int         IdxW       = $clog2(MaxResults);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BSL   = 2'd1,
        PH_BSL_X = 2'd2,
        PH_DIGIT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic       meta_warning;
        logic       null_warning;
    } res_t;

    typedef struct packed {
        res_t [MaxResults-1:0] ent;
        logic [CountW-1:0]     count;
    } batch_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Letters have low nibble 1..6, so adding 9 gives 10..15.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if (is_hex(c))
        begin
            v = c[3:0] + 4'd9;
        end
        else
        begin
            v = 4'd0;
        end
        return v;
    endfunction

    function automatic logic is_meta(input logic [7:0] v);
        logic m;
        case (v)
            8'h24, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2E, 8'h3F,
            8'h5B, 8'h5D, 8'h5E, 8'h7C, 8'h7B, 8'h7D, 8'h5C: m = 1'b1;
            default: m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/hexu_in_if.sv =====
// Input channel: one pattern character per request.
interface hexu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== sv/hexu_out_if.sv =====
// Output channel: one decoded character with its flags per request.
interface hexu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;
    logic       meta_warning;
    logic       null_warning;

    modport source (output valid, output out_byte, output is_last,
                    output meta_warning, output null_warning, input ready);
    modport sink (input valid, input out_byte, input is_last,
                  input meta_warning, input null_warning, output ready);
endinterface

// ===== sv/hexu_decode.sv =====
// Escape scanner: holds the sequence state and turns one character into a result batch.
module hexu_decode
    import hexu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_item_t item,
    output batch_t   batch
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    always_comb
    begin
        logic [7:0]        b;
        logic              hexb;
        logic              brk;
        phase_t            rp;
        logic [CountW-1:0] n;
        logic [CountW-1:0] nm1;
        logic [7:0]        dec;

        b          = item.in_byte;
        hexb       = is_hex(b);
        n          = '0;
        nm1        = '0;
        batch      = '0;
        phase_next = phase_reg;
        held_next  = held_reg;
        dec        = {hex_value(held_reg), hex_value(b)};

        // A sequence breaks on anything but 'x' after backslash, or a non-digit later.
        unique case (phase_reg)
            PH_IDLE:  brk = 1'b0;
            PH_BSL:   brk = (b != LetterX);
            PH_BSL_X: brk = !hexb;
            PH_DIGIT: brk = !hexb;
            default:  brk = 1'b0;
        endcase

        rp = phase_reg;
        if (brk)
        begin
            batch.ent[n[IdxW-1:0]] = '{out_byte: Backslash, default: 1'b0};
            n = n + 1'b1;
            if (phase_reg == PH_BSL_X || phase_reg == PH_DIGIT)
            begin
                batch.ent[n[IdxW-1:0]] = '{out_byte: LetterX, default: 1'b0};
                n = n + 1'b1;
            end
            if (phase_reg == PH_DIGIT)
            begin
                batch.ent[n[IdxW-1:0]] = '{out_byte: held_reg, default: 1'b0};
                n = n + 1'b1;
            end
            rp = PH_IDLE;
        end

        // breaking byte is rescanned from idle
        unique case (rp)
            PH_IDLE:
            begin
                if (b == Backslash)
                begin
                    phase_next = PH_BSL;
                end
                else
                begin
                    batch.ent[n[IdxW-1:0]] = '{out_byte: b, default: 1'b0};
                    n = n + 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_BSL:   phase_next = PH_BSL_X;
            PH_BSL_X:
            begin
                phase_next = PH_DIGIT;
                held_next  = b;
            end
            PH_DIGIT:
            begin
                batch.ent[n[IdxW-1:0]] = '{out_byte: dec, is_last: 1'b0,
                                          meta_warning: is_meta(dec),
                                          null_warning: (dec == 8'h00)};
                n = n + 1'b1;
                phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase

        if (item.end_of_string)
        begin
            if (phase_next != PH_IDLE)
            begin
                batch.ent[n[IdxW-1:0]] = '{out_byte: Backslash, default: 1'b0};
                n = n + 1'b1;
            end
            if (phase_next == PH_BSL_X || phase_next == PH_DIGIT)
            begin
                batch.ent[n[IdxW-1:0]] = '{out_byte: LetterX, default: 1'b0};
                n = n + 1'b1;
            end
            if (phase_next == PH_DIGIT)
            begin
                batch.ent[n[IdxW-1:0]] = '{out_byte: b, default: 1'b0};
                n = n + 1'b1;
            end
            phase_next = PH_IDLE;
            // end of string always yields at least one result
            nm1 = n - 1'b1;
            batch.ent[nm1[IdxW-1:0]].is_last = 1'b1;
        end
        batch.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== sv/hexu_outbuf.sv =====
// Result buffer: holds one decoded batch, sends one character per cycle if ready.
module hexu_outbuf
    import hexu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  batch_t batch,
    output logic  advance,
    hexu_out_if.source out_chan
);

    res_t [MaxResults-1:0] buf_reg;
    logic [CountW-1:0]     count_reg;
    logic [IdxW-1:0]       rd_reg;
    logic                  take;
    res_t                  cur;

    assign take    = out_chan.valid && out_chan.ready;
    // free for the next batch once the last held result leaves
    assign advance = (count_reg == '0) || (count_reg == CountW'(1) && out_chan.ready);
    assign cur     = buf_reg[rd_reg];

    assign out_chan.valid        = (count_reg != '0);
    assign out_chan.out_byte     = cur.out_byte;
    assign out_chan.is_last      = cur.is_last;
    assign out_chan.meta_warning = cur.meta_warning;
    assign out_chan.null_warning = cur.null_warning;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= '0;
        end
        else if (load)
        begin
            count_reg <= batch.count;
            rd_reg    <= '0;
        end
        else if (take)
        begin
            count_reg <= count_reg - 1'b1;
            rd_reg    <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= batch.ent;
        end
    end

endmodule

// ===== sv/hex_escape_unescaper.sv =====
// Hex escape decoder for pattern strings.
// in_chan takes one character per request with end_of_string on the final one.
// Every backslash, 'x', digit, digit sequence (either case) leaves as the byte it
// encodes, flagged by meta_warning for regex control characters and null_warning
// for byte zero; all other characters leave unchanged with both flags clear.
// Up to three characters of an unfinished sequence are held back; a broken
// sequence releases them raw ahead of whatever the breaking character gives.
// The final result of a string carries is_last.
// An accepted request is registered in the input register, decoded into the
// result buffer once that is free, and shows on out_chan from the result buffer.
// Throughput: one character per cycle while each yields at most one result and
// out_chan is ready; a character yielding several results (up to four) holds the
// result buffer until all have left; a request yielding none still loads it.
// Reset clears the input valid flag, the result count and the sequence phase.
// When out_chan stalls the current result holds, one further request waits in
// the input register, and in_chan.ready then drops.
module hex_escape_unescaper
    import hexu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    hexu_in_if.sink    in_chan,
    hexu_out_if.source out_chan
);

    logic     in_valid_reg;
    in_item_t in_reg;
    logic     advance;
    logic     step;
    batch_t   batch;

    assign step          = in_valid_reg && advance;
    assign in_chan.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_chan.valid && in_chan.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.valid && in_chan.ready)
        begin
            in_reg <= '{in_byte: in_chan.in_byte, end_of_string: in_chan.end_of_string};
        end
    end

    hexu_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_reg),
        .batch (batch)
    );

    hexu_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .batch    (batch),
        .advance  (advance),
        .out_chan (out_chan)
    );

endmodule

// ===== sv/hexu_checker.sv =====
// Port-level checks for the hex escape decoder, bound to the top level.
module hexu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       is_last,
    input logic       meta_warning,
    input logic       null_warning
);

`include "hex_escape_unescaper_assert.svh"

    // a stalled result holds
    `HEXU_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(is_last) && $stable(meta_warning)
        && $stable(null_warning), "stalled result changed")

    `HEXU_ASSERT_NOW(a_null_flag, clk, rst_n, out_valid && null_warning,
        out_byte == 8'h00 && !meta_warning, "null flag on non-zero byte")

    `HEXU_ASSERT_NOW(a_meta_flag, clk, rst_n, out_valid && meta_warning,
        out_byte != 8'h00 && !null_warning, "meta flag on zero byte")

    // with nothing waiting at the output the input side is always open
    `HEXU_ASSERT_NOW(a_idle_ready, clk, rst_n, !out_valid, in_ready,
        "input blocked while output empty")

endmodule

bind hex_escape_unescaper hexu_checker u_hexu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_chan.ready),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_byte     (out_chan.out_byte),
    .is_last      (out_chan.is_last),
    .meta_warning (out_chan.meta_warning),
    .null_warning (out_chan.null_warning)
);
